// ===== rtl/cpag_pkg.sv =====
// Shared types, constants and ray geometry for the attack generator pipeline.
`timescale 1ns / 1ps

package cpag_pkg;

  // Piece kinds; the two spare codes carry no attacks
  typedef enum logic [2:0] {
    PieceKnight  = 3'd0,
    PieceKing    = 3'd1,
    PiecePawn    = 3'd2,
    PieceBishop  = 3'd3,
    PieceRook    = 3'd4,
    PieceQueen   = 3'd5,
    PieceSpareLo = 3'd6,
    PieceSpareHi = 3'd7
  } piece_e;

  // Board-edge file masks
  localparam logic [63:0] FileNotA  = 64'hfefe_fefe_fefe_fefe;
  localparam logic [63:0] FileNotH  = 64'h7f7f_7f7f_7f7f_7f7f;
  localparam logic [63:0] FileNotAb = 64'hfcfc_fcfc_fcfc_fcfc;
  localparam logic [63:0] FileNotGh = 64'h3f3f_3f3f_3f3f_3f3f;

  // Ray directions: the first four are lines, the last four diagonals
  localparam int NumDir   = 8;
  localparam int NumLine  = 4;
  localparam int RayLen   = 7;

  localparam logic [2:0] DirN  = 3'd0;
  localparam logic [2:0] DirS  = 3'd1;
  localparam logic [2:0] DirE  = 3'd2;
  localparam logic [2:0] DirW  = 3'd3;
  localparam logic [2:0] DirNe = 3'd4;
  localparam logic [2:0] DirNw = 3'd5;
  localparam logic [2:0] DirSe = 3'd6;
  localparam logic [2:0] DirSw = 3'd7;

  typedef logic [NumDir-1:0][RayLen-1:0] ray_bits_t;

  // Stage 1 word: decoded query
  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  rank;
    logic [2:0]  file;
    logic [63:0] leap;
    logic [63:0] occ;
  } dec_t;

  // Stage 2 word: squares along each ray and their occupancy
  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  rank;
    logic [2:0]  file;
    logic [63:0] leap;
    ray_bits_t   on_board;
    ray_bits_t   occ_bits;
  } gath_t;

  // Stage 3 word: squares each ray reaches
  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  rank;
    logic [2:0]  file;
    logic [63:0] leap;
    ray_bits_t   reach;
  } ray_t;

  // Square a given number of steps along a direction: {on_board, index}
  function automatic logic [6:0] ray_target(input logic [2:0] rank, input logic [2:0] file,
                                            input logic [2:0] dir, input logic [2:0] step);
    logic signed [4:0] r;
    logic signed [4:0] f;
    logic signed [4:0] s;
    logic              on;
    r = $signed({2'b00, rank});
    f = $signed({2'b00, file});
    s = $signed({2'b00, step});
    case (dir)
      DirN:    r = r + s;
      DirS:    r = r - s;
      DirE:    f = f + s;
      DirW:    f = f - s;
      DirNe: begin
        r = r + s;
        f = f + s;
      end
      DirNw: begin
        r = r + s;
        f = f - s;
      end
      DirSe: begin
        r = r - s;
        f = f + s;
      end
      default: begin
        r = r - s;
        f = f - s;
      end
    endcase
    on = (r[4:3] == 2'b00) && (f[4:3] == 2'b00);
    return {on, r[2:0], f[2:0]};
  endfunction

endpackage

// ===== rtl/cpag_decode.sv =====
// Stage 1: decode the square and form knight, king and pawn attack sets.
`timescale 1ns / 1ps

module cpag_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [2:0]          action_i,
  input  logic [5:0]          square_i,
  input  logic                side_i,
  input  logic [63:0]         occupancy_i,
  output logic                valid_o,
  output cpag_pkg::dec_t      word_o
);

  logic           valid_q;
  cpag_pkg::dec_t word_d, word_q;
  logic [63:0]    b;
  logic [63:0]    knight, king, pawn;

  // Form the leaper patterns from the one-hot origin
  always_comb begin
    b = 64'd1 << square_i;
    knight = ((b & cpag_pkg::FileNotH)  << 17) | ((b & cpag_pkg::FileNotA)  << 15) |
             ((b & cpag_pkg::FileNotGh) << 10) | ((b & cpag_pkg::FileNotAb) << 6)  |
             ((b & cpag_pkg::FileNotGh) >> 6)  | ((b & cpag_pkg::FileNotAb) >> 10) |
             ((b & cpag_pkg::FileNotH)  >> 15) | ((b & cpag_pkg::FileNotA)  >> 17);
    king   = ((b & cpag_pkg::FileNotH) << 9) | ((b & cpag_pkg::FileNotA) << 7) | (b << 8) |
             ((b & cpag_pkg::FileNotH) << 1) | ((b & cpag_pkg::FileNotA) >> 1) |
             ((b & cpag_pkg::FileNotA) >> 9) | ((b & cpag_pkg::FileNotH) >> 7) | (b >> 8);
    if (side_i) begin
      pawn = ((b & cpag_pkg::FileNotA) >> 9) | ((b & cpag_pkg::FileNotH) >> 7);
    end else begin
      pawn = ((b & cpag_pkg::FileNotH) << 9) | ((b & cpag_pkg::FileNotA) << 7);
    end
  end

  // Pick the leaper set; sliders and unused kinds start empty
  always_comb begin
    word_d.kind = action_i;
    word_d.rank = square_i[5:3];
    word_d.file = square_i[2:0];
    word_d.occ  = occupancy_i;
    unique case (action_i)
      cpag_pkg::PieceKnight: word_d.leap = knight;
      cpag_pkg::PieceKing:   word_d.leap = king;
      cpag_pkg::PiecePawn:   word_d.leap = pawn;
      default:               word_d.leap = 64'd0;
    endcase
  end

  // Advance valid; the word needs no reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== rtl/cpag_gather.sv =====
// Stage 2: collect board position and occupancy of every square along the eight rays.
`timescale 1ns / 1ps

module cpag_gather (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  cpag_pkg::dec_t      word_i,
  output logic                valid_o,
  output cpag_pkg::gath_t     word_o
);

  logic            valid_q;
  cpag_pkg::gath_t word_d, word_q;

  // Look up each ray square and sample the occupancy there
  always_comb begin
    logic [6:0] tgt;
    word_d.kind = word_i.kind;
    word_d.rank = word_i.rank;
    word_d.file = word_i.file;
    word_d.leap = word_i.leap;
    for (int d = 0; d < cpag_pkg::NumDir; d++) begin
      for (int k = 0; k < cpag_pkg::RayLen; k++) begin
        tgt = cpag_pkg::ray_target(word_i.rank, word_i.file, 3'(d), 3'(k + 1));
        word_d.on_board[d][k] = tgt[6];
        word_d.occ_bits[d][k] = word_i.occ[tgt[5:0]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== rtl/cpag_ray.sv =====
// Stage 3: cut each ray after its first occupied square.
`timescale 1ns / 1ps

module cpag_ray (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  cpag_pkg::gath_t     word_i,
  output logic                valid_o,
  output cpag_pkg::ray_t      word_o
);

  logic           valid_q;
  cpag_pkg::ray_t word_d, word_q;

  // Keep a square while no earlier square on the ray is occupied
  always_comb begin
    logic open;
    word_d.kind = word_i.kind;
    word_d.rank = word_i.rank;
    word_d.file = word_i.file;
    word_d.leap = word_i.leap;
    for (int d = 0; d < cpag_pkg::NumDir; d++) begin
      open = 1'b1;
      for (int k = 0; k < cpag_pkg::RayLen; k++) begin
        word_d.reach[d][k] = word_i.on_board[d][k] & open;
        open = open & ~word_i.occ_bits[d][k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== rtl/cpag_merge.sv =====
// Stage 4: scatter reached ray squares onto the board and merge with leaper sets.
`timescale 1ns / 1ps

module cpag_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  cpag_pkg::ray_t      word_i,
  output logic                valid_o,
  output logic [63:0]         board_o
);

  logic        valid_q;
  logic [63:0] board_d, board_q;
  logic        line_en, diag_en;

  // Enable line rays for rook and queen, diagonals for bishop and queen
  assign line_en = (word_i.kind == cpag_pkg::PieceRook) ||
                   (word_i.kind == cpag_pkg::PieceQueen);
  assign diag_en = (word_i.kind == cpag_pkg::PieceBishop) ||
                   (word_i.kind == cpag_pkg::PieceQueen);

  // Set one board bit for every reached square of an enabled ray
  always_comb begin
    logic [6:0] tgt;
    logic       en;
    board_d = word_i.leap;
    for (int d = 0; d < cpag_pkg::NumDir; d++) begin
      en = (d < cpag_pkg::NumLine) ? line_en : diag_en;
      for (int k = 0; k < cpag_pkg::RayLen; k++) begin
        tgt = cpag_pkg::ray_target(word_i.rank, word_i.file, 3'(d), 3'(k + 1));
        if (en && word_i.reach[d][k]) begin
          board_d[tgt[5:0]] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    board_q <= board_d;
  end

  assign valid_o = valid_q;
  assign board_o = board_q;

endmodule

// ===== rtl/chess_piece_attack_generator_core.sv =====
// Top level of the chess piece attack generator pipeline.
`timescale 1ns / 1ps
//
// Usage:
//   Drive action_i, square_i, side_i and occupancy_i and raise start_i; the
//   query word is taken at the clock edge where start_i is high and busy_o is
//   low. busy_o stays low, so a new query may be issued on every cycle.
//   Each query yields one attacked_o board, shown for exactly one cycle with
//   done_o high, in the order the queries were issued.
// Pipeline and throughput:
//   Four register stages (decode and leaper sets, ray gather, ray cut,
//   scatter and merge), passed through in that order.
//   One query per cycle sustained; every stage moves forward each cycle.
// Reset:
//   rst_ni low clears all stage valid bits at once; queries in flight are
//   dropped and done_o stays low until new queries come out.
// Output:
//   The receiver must take each result in its cycle; there is no hold-off.

module chess_piece_attack_generator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  action_i,
  input  logic [5:0]  square_i,
  input  logic        side_i,
  input  logic [63:0] occupancy_i,
  output logic        done_o,
  output logic [63:0] attacked_o
);

  logic            accept;
  logic            s1_valid, s2_valid, s3_valid;
  cpag_pkg::dec_t  s1_word;
  cpag_pkg::gath_t s2_word;
  cpag_pkg::ray_t  s3_word;

  // Pipeline never stalls: take a query whenever start is high
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  cpag_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .action_i    (action_i),
    .square_i    (square_i),
    .side_i      (side_i),
    .occupancy_i (occupancy_i),
    .valid_o     (s1_valid),
    .word_o      (s1_word)
  );

  cpag_gather u_gather (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .word_i  (s1_word),
    .valid_o (s2_valid),
    .word_o  (s2_word)
  );

  cpag_ray u_ray (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .word_i  (s2_word),
    .valid_o (s3_valid),
    .word_o  (s3_word)
  );

  cpag_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_valid),
    .word_i  (s3_word),
    .valid_o (done_o),
    .board_o (attacked_o)
  );

  // Every accepted query comes out as a result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##3 done_o)
    else $error("query did not complete after four stages");

  // No result without a matching earlier query
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 4))
    else $error("result without a matching query");

  // A piece never attacks its own square
  a_no_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !attacked_o[$past(square_i, 4)])
    else $error("origin square marked as attacked");

  // Unused piece kinds give an empty board
  a_unused_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && ($past(action_i, 4) == cpag_pkg::PieceSpareLo ||
               $past(action_i, 4) == cpag_pkg::PieceSpareHi)
      |-> attacked_o == 64'd0)
    else $error("unused piece kind produced attacks");

  // Knight and king reach at most eight squares
  a_leaper_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && ($past(action_i, 4) == cpag_pkg::PieceKnight ||
               $past(action_i, 4) == cpag_pkg::PieceKing)
      |-> $countones(attacked_o) <= 8)
    else $error("leaper attack set too large");

endmodule
